@@ rtl/urlpd_pkg.sv @@
// Shared types, character constants and hex helpers for the URL percent decoder.
// Used by all modules under rtl/; depends on nothing else.
`default_nettype none

package urlpd_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;

    // Character codes
    localparam logic [BYTE_W-1:0] PCT_CHAR = 8'h25;
    localparam logic [BYTE_W-1:0] DIGIT_0  = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_9  = 8'h39;
    localparam logic [BYTE_W-1:0] UPPER_A  = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_F  = 8'h46;
    localparam logic [BYTE_W-1:0] LOWER_A  = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_F  = 8'h66;

    // Escape scanner state
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } urlpd_phase_t;

    // One queue entry: all result bytes caused by one input item
    typedef struct packed {
        logic [1:0]                        cnt;      // 1 to 3 bytes
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;   // slot 0 goes out first
        logic                              msg_end;  // item carried the final flag
    } urlpd_entry_t;

    function automatic logic hex_ok(input logic [BYTE_W-1:0] b);
        return ((b >= DIGIT_0) && (b <= DIGIT_9)) ||
               ((b >= UPPER_A) && (b <= UPPER_F)) ||
               ((b >= LOWER_A) && (b <= LOWER_F));
    endfunction

    function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        d = '0;
        if ((b >= DIGIT_0) && (b <= DIGIT_9)) begin
            d = b - DIGIT_0;
        end else if ((b >= UPPER_A) && (b <= UPPER_F)) begin
            d = b - UPPER_A + 8'd10;
        end else if ((b >= LOWER_A) && (b <= LOWER_F)) begin
            d = b - LOWER_A + 8'd10;
        end
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/url_percent_decoder_top.sv @@
// Entries are queued, then sent out through the output register. Throughput: one
// input byte per cycle while the queue has room, one output byte per cycle while
// m_tready allows. A two- or three-byte input keeps the back end busy until all
// its bytes are out; the QUEUE_DEPTH-entry queue sets how long input flows meanwhile.
// Reset: synchronous active-low aresetn clears scanner phase, queue and output valid.
`default_nettype none

module url_percent_decoder_top #(
    parameter int QUEUE_DEPTH = urlpd_pkg::QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // is_final
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,   // run_end
    output logic            m_tuser    // message_end
);
    import urlpd_pkg::*;

    logic          q_push, q_pop, q_full, q_empty;
    urlpd_entry_t  q_entry, q_head;

    urlpd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    urlpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    urlpd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

@@ rtl/urlpd_front.sv @@
// Front end: accepts input bytes, runs the escape scanner and forms queue entries.
// Depends on urlpd_pkg.
`default_nettype none

module urlpd_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] in_byte
    input  wire logic                 s_tlast,   // is_final
    input  wire logic                 q_full,
    output logic                      q_push,
    output urlpd_pkg::urlpd_entry_t   q_entry
);
    import urlpd_pkg::*;

    urlpd_phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]         held_reg, held_next;

    logic                      s_accept;
    logic                      is_hex, is_pct;
    logic                      pre_pct, pre_held, dec_go, fresh_go;
    urlpd_phase_t              scan_phase;
    logic [1:0]                n;
    logic [MAX_RESULTS-1:0][BYTE_W-1:0] slots;

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;
    assign is_hex   = hex_ok(s_tdata);
    assign is_pct   = (s_tdata == PCT_CHAR);

    // Classify the byte against the current phase
    always_comb begin
        pre_pct    = 1'b0;
        pre_held   = 1'b0;
        dec_go     = 1'b0;
        fresh_go   = 1'b0;
        scan_phase = PH_IDLE;
        held_next  = held_reg;
        case (phase_reg)
            PH_PCT: begin
                if (is_hex) begin
                    scan_phase = PH_DIGIT;
                    held_next  = s_tdata;
                end else begin
                    pre_pct  = 1'b1;
                    fresh_go = 1'b1;
                end
            end
            PH_DIGIT: begin
                if (is_hex) begin
                    dec_go = 1'b1;
                end else begin
                    pre_pct  = 1'b1;
                    pre_held = 1'b1;
                    fresh_go = 1'b1;
                end
            end
            default: begin
                fresh_go = 1'b1;
            end
        endcase
        if (fresh_go) begin
            scan_phase = is_pct ? PH_PCT : PH_IDLE;
        end
    end

    // Pack result bytes into slots in emission order
    always_comb begin
        n     = 2'd0;
        slots = '0;
        if (pre_pct) begin
            slots[n] = PCT_CHAR;
            n = n + 2'd1;
        end
        if (pre_held) begin
            slots[n] = held_reg;
            n = n + 2'd1;
        end
        if (dec_go) begin
            slots[n] = {hex_val(held_reg), hex_val(s_tdata)};
            n = n + 2'd1;
        end
        if (fresh_go && !is_pct) begin
            slots[n] = s_tdata;
            n = n + 2'd1;
        end
        // End of message flushes a pending escape literally
        if (s_tlast && (scan_phase != PH_IDLE)) begin
            slots[n] = PCT_CHAR;
            n = n + 2'd1;
            if (scan_phase == PH_DIGIT) begin
                slots[n] = held_next;
                n = n + 2'd1;
            end
        end
        phase_next = s_tlast ? PH_IDLE : scan_phase;
    end

    assign q_push          = s_accept && (n != 2'd0);
    assign q_entry.cnt     = n;
    assign q_entry.bytes   = slots;
    assign q_entry.msg_end = s_tlast;

    // Scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (s_accept) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            held_reg <= held_next;
        end
    end

`ifndef SYNTH
    // A final byte always yields a queue entry marked as message end
    a_final_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |-> (q_push && q_entry.msg_end))
        else $error("final item did not push a message-end entry");
`endif

endmodule

`default_nettype wire

@@ rtl/urlpd_queue.sv @@
// Short register queue of result entries between front and back end.
// Depends on urlpd_pkg.
`default_nettype none

module urlpd_queue #(
    parameter int DEPTH = urlpd_pkg::QUEUE_DEPTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire urlpd_pkg::urlpd_entry_t push_entry,
    output logic                         full,
    input  wire logic                    pop,
    output logic                         empty,
    output urlpd_pkg::urlpd_entry_t      head
);
    import urlpd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    urlpd_entry_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

@@ rtl/urlpd_back.sv @@
// Back end: serializes queued entries into one output item per cycle, while m_tready allows, through an
// output register. Depends on urlpd_pkg.
`default_nettype none

module urlpd_back (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    q_empty,
    input  wire urlpd_pkg::urlpd_entry_t q_head,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [7:0]                   m_tdata,   // [7:0] out_byte
    output logic                         m_tlast,   // run_end
    output logic                         m_tuser    // message_end
);
    import urlpd_pkg::*;

    logic [1:0]         idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_run_end_reg, out_msg_end_reg;

    logic               load, slot_last;

    assign load      = (!out_valid_reg || m_tready) && !q_empty;
    assign slot_last = (idx_reg == (q_head.cnt - 2'd1));
    assign q_pop     = load && slot_last;

    // Slot index within the head entry
    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = slot_last ? 2'd0 : idx_reg + 2'd1;
        end
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg    <= q_head.bytes[idx_reg];
            out_run_end_reg <= slot_last;
            out_msg_end_reg <= slot_last && q_head.msg_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_run_end_reg;
    assign m_tuser  = out_msg_end_reg;

`ifndef SYNTH
    // Slot index never runs past the head entry's byte count
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_empty |-> (idx_reg < q_head.cnt))
        else $error("slot index beyond entry count");
`endif

endmodule

`default_nettype wire

@@ sim/tb_url_percent_decoder_top.sv @@
// Self-checking testbench for url_percent_decoder_top: directed escapes, then random messages.
// Depends on urlpd_pkg (character codes, phase enum) and the RTL under rtl/.
module tb_url_percent_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import urlpd_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int MAX_GAP     = 16;
    localparam int TAIL_CYCLES = 8;

    // One decoded byte as it should leave the block
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       message_end;
    } dec_result_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    // Scanner copy used for prediction
    urlpd_phase_t scan_phase;
    logic [7:0]   held_char;
    logic [7:0]   run_bytes[$];
    dec_result_t  decoded_q[$];
    dec_result_t  want;

    int          fail_count;
    int          cycle_count;
    int unsigned rx_wait;
    bit          tx_idle;
    bit          rx_idle;

    url_percent_decoder_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // {valid, nibble} for one character
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= DIGIT_0 && c <= DIGIT_9) begin
            d = c - DIGIT_0;
            return {1'b1, d[3:0]};
        end
        if (c >= UPPER_A && c <= UPPER_F) begin
            d = c - UPPER_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= LOWER_A && c <= LOWER_F) begin
            d = c - LOWER_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'b0;
    endfunction

    // Byte seen with no escape pending
    function automatic void scan_plain(input logic [7:0] c);
        if (c == PCT_CHAR) begin
            scan_phase = PH_PCT;
        end else begin
            scan_phase = PH_IDLE;
            run_bytes.push_back(c);
        end
    endfunction

    // Advance the scanner by one accepted item and queue what it should emit
    function automatic void predict_decode(input logic [7:0] c, input logic fin);
        logic [4:0]  hi;
        logic [4:0]  lo;
        dec_result_t r;
        lo = hex_digit(c);
        case (scan_phase)
            PH_PCT: begin
                if (lo[4]) begin
                    held_char  = c;
                    scan_phase = PH_DIGIT;
                end else begin
                    run_bytes.push_back(PCT_CHAR);
                    scan_plain(c);
                end
            end
            PH_DIGIT: begin
                hi = hex_digit(held_char);
                if (lo[4]) begin
                    run_bytes.push_back({hi[3:0], lo[3:0]});
                    scan_phase = PH_IDLE;
                end else begin
                    // broken after one digit: '%', the digit, then the byte afresh
                    run_bytes.push_back(PCT_CHAR);
                    run_bytes.push_back(held_char);
                    scan_plain(c);
                end
                held_char = 8'h00;
            end
            default: scan_plain(c);
        endcase
        // end of message flushes whatever escape is still open
        if (fin) begin
            if (scan_phase == PH_PCT) begin
                run_bytes.push_back(PCT_CHAR);
            end else if (scan_phase == PH_DIGIT) begin
                run_bytes.push_back(PCT_CHAR);
                run_bytes.push_back(held_char);
            end
            scan_phase = PH_IDLE;
            held_char  = 8'h00;
        end
        foreach (run_bytes[i]) begin
            r.out_byte    = run_bytes[i];
            r.run_end     = (i == run_bytes.size() - 1);
            r.message_end = r.run_end && fin;
            decoded_q.push_back(r);
        end
        run_bytes.delete();
    endfunction

    function automatic logic [7:0] rand_hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 8'd10) begin
            return DIGIT_0 + v;
        end
        return ($urandom_range(0, 1) != 0) ? UPPER_A + v - 8'd10 : LOWER_A + v - 8'd10;
    endfunction

    // Non-hex byte, biased toward the neighbors of the hex ranges
    function automatic logic [7:0] rand_nonhex_char();
        logic [7:0] c;
        logic [4:0] h;
        case ($urandom_range(0, 9))
            0: c = DIGIT_0 - 8'd1;
            1: c = DIGIT_9 + 8'd1;
            2: c = UPPER_A - 8'd1;
            3: c = UPPER_F + 8'd1;
            4: c = LOWER_A - 8'd1;
            5: c = LOWER_F + 8'd1;
            6: c = PCT_CHAR;
            default: begin
                do begin
                    c = 8'($urandom_range(0, 255));
                    h = hex_digit(c);
                end while (h[4]);
            end
        endcase
        return c;
    endfunction

    // Send one item, with a random lead-in gap while tx_idle is set; predict once it is taken
    task automatic send_item(input logic [7:0] c, input logic fin);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_decode(c, fin);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], i == s.len() - 1);
        end
    endtask

    // Sender holds off until every expected byte has come out
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_plain_bytes();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h7F, 1'b1);
    endtask

    // Decodes to 0x00 and 0xFF, mixed case digits
    task automatic test_valid_escapes();
        send_text("%00%fF");
    endtask

    // Broken after '%', and broken after one digit by a new '%'
    task automatic test_broken_escapes();
        send_text("%G%4%41");
    endtask

    // Messages that end with '%' or one digit still pending, or with an escape broken by the final byte
    task automatic test_cut_short();
        send_text("%");
        send_text("%4");
        send_text("%4Z");
        send_text("%4%");
    endtask

    // Messages of escapes, broken escapes and raw bytes
    task automatic test_random_messages(input int unsigned n_items);
        logic [7:0]  msg[$];
        int unsigned sent;
        int unsigned n_parts;
        sent = 0;
        while (sent < n_items) begin
            msg.delete();
            n_parts = $urandom_range(1, 6);
            for (int k = 0; k < n_parts; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        msg.push_back(PCT_CHAR);
                        msg.push_back(rand_hex_char());
                        msg.push_back(rand_hex_char());
                    end
                    6: begin
                        msg.push_back(PCT_CHAR);
                        msg.push_back(rand_nonhex_char());
                    end
                    7: begin
                        msg.push_back(PCT_CHAR);
                        msg.push_back(rand_hex_char());
                        msg.push_back(rand_nonhex_char());
                    end
                    default: msg.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            // sometimes drop the last byte, which may cut the message short inside an escape
            if ($urandom_range(0, 5) == 0 && msg.size() > 1) begin
                void'(msg.pop_back());
            end
            foreach (msg[i]) begin
                send_item(msg[i], i == msg.size() - 1);
            end
            sent += msg.size();
        end
    endtask

    // Receiver stall per item
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected result item: out_byte %02h", m_tdata);
                fail_count++;
            end else begin
                want = decoded_q.pop_front();
                if (m_tdata !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.run_end) begin
                    $error("run_end: expected %0b, got %0b", want.run_end, m_tlast);
                    fail_count++;
                end
                if (m_tuser !== want.message_end) begin
                    $error("message_end: expected %0b, got %0b", want.message_end, m_tuser);
                    fail_count++;
                end
            end
            rx_wait = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        rx_wait    = 0;
        fail_count = 0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        scan_phase = PH_IDLE;
        held_char  = 8'h00;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_plain_bytes();
        test_valid_escapes();
        test_broken_escapes();
        test_cut_short();
        test_random_messages(50);
        wait_drained();
        tx_idle = 1'b0;
        test_random_messages(50);
        rx_idle = 1'b0;
        test_random_messages(50);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ url_percent_decoder_top.f @@
rtl/urlpd_pkg.sv
rtl/urlpd_front.sv
rtl/urlpd_queue.sv
rtl/urlpd_back.sv
rtl/url_percent_decoder_top.sv
sim/tb_url_percent_decoder_top.sv
